// File: design/ifp_pkg.sv
// ----------------------------------------------------------------------------
// ifp_pkg
// Shared codes, types and the arctangent table for the IMU frame parser.
// ----------------------------------------------------------------------------
package ifp_pkg;

	localparam logic [7:0] SYNC_BYTE = 8'h55;
	localparam logic [7:0] ID_ANGLE  = 8'h53;
	localparam logic [7:0] ID_MAG    = 8'h54;
	localparam logic [15:0] DELAY_RESET = 16'd5000;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Width of the CORDIC x/y datapath: 16-bit word scaled by 2^16 plus gain headroom.
	localparam int CW = 35;

	typedef struct packed {
		logic busy;
		logic done;
	} cordic_stat_t;

	// atan(2^-i) in units of 2^-32 turn.
	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'd536870912;
			5'd1:  r = 32'd316933406;
			5'd2:  r = 32'd167458907;
			5'd3:  r = 32'd85004756;
			5'd4:  r = 32'd42667331;
			5'd5:  r = 32'd21354465;
			5'd6:  r = 32'd10680862;
			5'd7:  r = 32'd5340245;
			5'd8:  r = 32'd2670163;
			5'd9:  r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41721;
			5'd15: r = 32'd20860;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2607;
			5'd19: r = 32'd1303;
			5'd20: r = 32'd651;
			5'd21: r = 32'd325;
			5'd22: r = 32'd162;
			5'd23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

// File: design/ifp_if.sv
// ----------------------------------------------------------------------------
// ifp_in_if / ifp_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface ifp_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] data_byte;
	modport source (output valid, output op, output data_byte, input ready);
	modport sink (input valid, input op, input data_byte, output ready);
endinterface

interface ifp_out_if;
	logic               valid;
	logic               ready;
	logic signed [16:0] roll_rel;
	logic signed [16:0] pitch_rel;
	logic [15:0]        yaw_sensor_rel;
	logic [15:0]        yaw_mag_rel;
	modport source (output valid, output roll_rel, output pitch_rel,
		output yaw_sensor_rel, output yaw_mag_rel, input ready);
	modport sink (input valid, input roll_rel, input pitch_rel,
		input yaw_sensor_rel, input yaw_mag_rel, output ready);
endinterface

// File: design/ifp_cordic.sv
// ----------------------------------------------------------------------------
// ifp_cordic
// Iterative vectoring CORDIC, one micro-rotation per cycle, binary-angle out.
// ----------------------------------------------------------------------------
module ifp_cordic #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [15:0]  mx,
	input  logic signed [15:0]  my,
	output ifp_pkg::cordic_stat_t stat,
	output logic [15:0]         heading
);
	localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam int CW = ifp_pkg::CW;

	logic                 busy_q;
	logic                 done_q;
	logic [IW-1:0]        step_q;
	logic signed [CW-1:0] x_q;
	logic signed [CW-1:0] y_q;
	logic [31:0]          acc_q;
	logic signed [CW-1:0] x0;
	logic signed [CW-1:0] y0;
	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;
	logic [31:0]          acc_rnd;

	assign x0 = {{(CW-32){mx[15]}}, mx, 16'h0000};
	assign y0 = {{(CW-32){my[15]}}, my, 16'h0000};
	assign xs = x_q >>> step_q;
	assign ys = y_q >>> step_q;
	assign acc_rnd = acc_q + 32'd32768;
	assign heading = acc_rnd[31:16];
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == IW'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// pre-rotate the left half plane by half a turn
			if (mx[15]) begin
				x_q   <= -x0;
				y_q   <= -y0;
				acc_q <= 32'h8000_0000;
			end else begin
				x_q   <= x0;
				y_q   <= y0;
				acc_q <= 32'h0;
			end
		end else if (busy_q) begin
			if (y_q > 0) begin
				x_q   <= x_q + ys;
				y_q   <= y_q - xs;
				acc_q <= acc_q + ifp_pkg::atan_turn(5'(step_q));
			end else if (y_q < 0) begin
				x_q   <= x_q - ys;
				y_q   <= y_q + xs;
				acc_q <= acc_q - ifp_pkg::atan_turn(5'(step_q));
			end
		end
	end

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("done while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("done held");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("start while busy");

endmodule

// File: design/imu_frame_parser_relative_angles.sv
// ----------------------------------------------------------------------------
// imu_frame_parser_relative_angles
// Frames sensor packets and reports angles relative to a latched zero.
// ----------------------------------------------------------------------------
// Each input item is either a received serial byte or a millisecond tick. The
// last byte of a packet is followed by a decode cycle in which the packet is
// decoded; an angle packet, once the calibration delay has elapsed, then drops
// its result into the output register, which holds it until taken (the decode
// cycle waits only if that register is still full). A magnetometer packet
// runs the iterative CORDIC, one micro-rotation per cycle, and the block
// accepts nothing until the CORDIC is done and its heading is stored.
// Angles are binary-angle units; yaw values wrap modulo one turn.
// ----------------------------------------------------------------------------
module imu_frame_parser_relative_angles #(
	parameter int FRAME_LEN    = 11,
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	ifp_in_if.sink      din,
	ifp_out_if.source   dout
);
	logic [15:0]  delay_q;
	logic         in_frame_q;
	logic [3:0]   cnt_q;
	logic [7:0]   store_q [7];
	logic [15:0]  ticks_q;
	logic         calib_q;
	logic [15:0]  mag_q;
	logic [15:0]  off_q [4];
	logic         fin_q;
	logic         out_valid_q;
	logic signed [16:0] roll_q;
	logic signed [16:0] pitch_q;
	logic [15:0]  yaw_s_q;
	logic [15:0]  yaw_m_q;

	logic         accept;
	logic [4:0]   cnt_nxt;
	logic [15:0]  w0, w1, w2;
	logic         calib_now;
	logic         cordic_start;
	ifp_pkg::cordic_stat_t cstat;
	logic [15:0]  heading;
	logic [15:0]  o0, o1, o2, o3;
	logic         out_free;
	logic         out_load;

	ifp_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cordic_start),
		.mx(w0), .my(w1), .stat(cstat), .heading(heading)
	);

	// hold input while a packet is decoded or the heading is in flight
	assign din.ready = !fin_q && !cstat.busy && !cstat.done;
	assign accept = din.valid && din.ready;
	assign cnt_nxt = {1'b0, cnt_q} + 5'd1;

	assign w0 = {store_q[2], store_q[1]};
	assign w1 = {store_q[4], store_q[3]};
	assign w2 = {store_q[6], store_q[5]};
	assign calib_now = calib_q || (ticks_q >= delay_q);
	assign cordic_start = fin_q && (store_q[0] == ifp_pkg::ID_MAG);
	assign out_free = !out_valid_q || dout.ready;
	// load a result into the output register this cycle
	assign out_load = fin_q && (store_q[0] == ifp_pkg::ID_ANGLE) && calib_now && out_free;

	// first calibrating packet sees its own values as offsets
	assign o0 = calib_q ? off_q[0] : w0;
	assign o1 = calib_q ? off_q[1] : w1;
	assign o2 = calib_q ? off_q[2] : w2;
	assign o3 = calib_q ? off_q[3] : mag_q;

	assign dout.valid          = out_valid_q;
	assign dout.roll_rel       = roll_q;
	assign dout.pitch_rel      = pitch_q;
	assign dout.yaw_sensor_rel = yaw_s_q;
	assign dout.yaw_mag_rel    = yaw_m_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q     <= ifp_pkg::DELAY_RESET;
			in_frame_q  <= 1'b0;
			cnt_q       <= '0;
			ticks_q     <= '0;
			calib_q     <= 1'b0;
			mag_q       <= '0;
			off_q       <= '{default: '0};
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				delay_q <= cfg_wdata;
			end
			if (out_valid_q && dout.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			if (cstat.done) begin
				mag_q <= heading;
			end
			if (accept && din.op == ifp_pkg::OP_TICK) begin
				// saturate, never wrap
				if (ticks_q != 16'hFFFF) begin
					ticks_q <= ticks_q + 16'd1;
				end
			end else if (accept) begin
				if (!in_frame_q) begin
					if (din.data_byte == ifp_pkg::SYNC_BYTE) begin
						in_frame_q <= 1'b1;
						cnt_q      <= 4'd1;
					end
				end else if (cnt_nxt >= 5'(FRAME_LEN)) begin
					in_frame_q <= 1'b0;
					cnt_q      <= '0;
					fin_q      <= 1'b1;
				end else begin
					cnt_q <= cnt_nxt[3:0];
				end
			end
			if (fin_q) begin
				if (store_q[0] == ifp_pkg::ID_ANGLE && calib_now) begin
					// wait for the output register to drain
					if (out_free) begin
						fin_q       <= 1'b0;
						out_valid_q <= 1'b1;
						if (!calib_q) begin
							calib_q  <= 1'b1;
							off_q[0] <= w0;
							off_q[1] <= w1;
							off_q[2] <= w2;
							off_q[3] <= mag_q;
						end
					end
				end else begin
					fin_q <= 1'b0;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept && din.op == ifp_pkg::OP_BYTE && in_frame_q
				&& !cnt_q[3] && cnt_q != 4'd0) begin
			store_q[cnt_q[2:0] - 3'd1] <= din.data_byte;
		end
		if (out_load) begin
			roll_q  <= $signed({w0[15], w0}) - $signed({o0[15], o0});
			pitch_q <= $signed({w1[15], w1}) - $signed({o1[15], o1});
			yaw_s_q <= w2 - o2;
			yaw_m_q <= mag_q - o3;
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cstat.busy || fin_q) |-> !din.ready) else $error("accept during decode");
	a_calib_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		calib_q |=> calib_q) else $error("calibration lost");
	a_result_calib: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> calib_q) else $error("result before calibration");
	a_frame_count: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> cnt_q == 4'd0) else $error("count outside frame");

endmodule
